// File: rtl/core/apfp_pkg.sv
// ----------------------------------------------------------------------------
// apfp_pkg
// Shared types, constants and helpers for the ASCII pose frame parser.
// ----------------------------------------------------------------------------
package apfp_pkg;

	localparam int APFP_MAX_FRAME = 30;
	localparam int KEPT_BYTES     = 12;

	localparam logic [7:0] START_CHAR = 8'h4D;  // 'M'
	localparam logic [7:0] CR_CHAR    = 8'h0D;
	localparam logic [7:0] LF_CHAR    = 8'h0A;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] MINUS_CHAR = 8'h2D;

	localparam int X_W = 15;
	localparam int Z_W = 15;
	localparam int H_W = 11;

	// bytes of the current frame as the decoders see them; unreceived read zero
	typedef struct packed {
		logic                          done;
		logic [KEPT_BYTES-1:0][7:0]    bytes;
	} frame_view_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

// File: rtl/core/apfp_field_dec.sv
// ----------------------------------------------------------------------------
// apfp_field_dec
// Decodes one fixed-width character field as a signed decimal number:
// leading blanks, optional sign, digits up to the first non-digit.
// ----------------------------------------------------------------------------
module apfp_field_dec
	import apfp_pkg::*;
#(
	parameter int LEN   = 4,
	parameter int OUT_W = 15
) (
	input  logic [LEN-1:0][7:0]      chars,
	output logic signed [OUT_W-1:0]  value
);

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	phase_t           phase;
	logic             neg;
	logic [OUT_W-1:0] acc;

	always_comb begin
		phase = PH_SKIP;
		neg   = 1'b0;
		acc   = '0;
		for (int i = 0; i < LEN; i++) begin
			case (phase)
				PH_SKIP: begin
					if (is_blank(chars[i])) begin
						phase = PH_SKIP;
					end else if (chars[i] == PLUS_CHAR || chars[i] == MINUS_CHAR) begin
						neg   = (chars[i] == MINUS_CHAR);
						phase = PH_DIGITS;
					end else if (is_digit(chars[i])) begin
						acc   = OUT_W'(chars[i][3:0]);
						phase = PH_DIGITS;
					end else begin
						phase = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit(chars[i])) begin
						acc = OUT_W'(acc * OUT_W'(10)) + OUT_W'(chars[i][3:0]);
					end else begin
						phase = PH_DONE;
					end
				end
				default: begin
					phase = PH_DONE;
				end
			endcase
		end
	end

	assign value = neg ? $signed(OUT_W'(-acc)) : $signed(acc);

endmodule

// File: rtl/core/apfp_frame.sv
// ----------------------------------------------------------------------------
// apfp_frame
// Frame collector: byte count, first twelve bytes and the previous byte;
// flags a completed frame on CR LF and clears itself on done or error.
// ----------------------------------------------------------------------------
module apfp_frame
	import apfp_pkg::*;
#(
	parameter int MAX_FRAME = APFP_MAX_FRAME
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   byte_in,
	output frame_view_t  view
);

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	logic [CNT_W-1:0]            count_q;
	logic [7:0]                  prev_q;
	logic [KEPT_BYTES-1:0][7:0]  frame_q;

	logic       over;
	logic       bad_start;
	logic       done;
	logic [7:0] first_byte;

	assign over       = (count_q >= CNT_W'(MAX_FRAME));
	assign first_byte = (count_q == '0) ? byte_in : frame_q[0];
	assign bad_start  = (first_byte != START_CHAR);
	assign done       = !over && !bad_start && (count_q != '0)
	                    && (byte_in == LF_CHAR) && (prev_q == CR_CHAR);

	// positions at or past the count have never been written in this frame
	always_comb begin
		view.done = done;
		for (int i = 0; i < KEPT_BYTES; i++) begin
			if (CNT_W'(i) < count_q) begin
				view.bytes[i] = frame_q[i];
			end else if (CNT_W'(i) == count_q) begin
				view.bytes[i] = byte_in;
			end else begin
				view.bytes[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev_q  <= '0;
		end else if (step) begin
			if (over || bad_start || done) begin
				count_q <= '0;
				prev_q  <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				prev_q  <= byte_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !over && (count_q < CNT_W'(KEPT_BYTES))) begin
			frame_q[count_q[3:0]] <= byte_in;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME))
		else $error("frame count beyond limit");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> count_q == '0)
		else $error("frame not cleared after completion");

	a_over_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && over |=> count_q == '0 && prev_q == '0)
		else $error("overlong frame not dropped");

endmodule

// File: rtl/core/ascii_pose_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_pose_frame_parser_unit
// Collects 'M' ... CR LF frames from a byte stream and returns the decoded
// x, z and heading fields of each completed frame.
// ----------------------------------------------------------------------------
// Path: the LF passes the input register, then the result register; it waits in
// the input register while an earlier result is held at the output and not taken.
// Throughput: one byte per cycle unless a held result stalls the input; the input
// register and the result register let a byte enter while an earlier result waits.
// Reset: arst_n clears the frame count, previous byte and both valid flags;
// stored frame bytes are not reset (positions past the count read as zero).
module ascii_pose_frame_parser_unit
	import apfp_pkg::*;
#(
	parameter int MAX_FRAME = APFP_MAX_FRAME
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [X_W-1:0] x_position,
	output logic signed [Z_W-1:0] z_position,
	output logic signed [H_W-1:0] heading
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv_s1;
	logic       step;

	frame_view_t view;

	logic signed [X_W-1:0] x_dec;
	logic signed [Z_W-1:0] z_dec;
	logic signed [H_W-1:0] h_dec;

	logic                  out_valid_q;
	logic signed [X_W-1:0] x_q;
	logic signed [Z_W-1:0] z_q;
	logic signed [H_W-1:0] h_q;

	assign adv_s1   = !out_valid_q || out_ready;
	assign step     = valid_s1 && adv_s1;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	apfp_frame #(
		.MAX_FRAME (MAX_FRAME)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_in (byte_s1),
		.view    (view)
	);

	apfp_field_dec #(.LEN(4), .OUT_W(X_W)) u_dec_x (
		.chars (view.bytes[4:1]),
		.value (x_dec)
	);

	apfp_field_dec #(.LEN(4), .OUT_W(Z_W)) u_dec_z (
		.chars (view.bytes[8:5]),
		.value (z_dec)
	);

	apfp_field_dec #(.LEN(3), .OUT_W(H_W)) u_dec_h (
		.chars (view.bytes[11:9]),
		.value (h_dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1 && view.done;
		end
	end

	always_ff @(posedge clk) begin
		if (step && view.done) begin
			x_q <= x_dec;
			z_q <= z_dec;
			h_q <= h_dec;
		end
	end

	assign out_valid  = out_valid_q;
	assign x_position = x_q;
	assign z_position = z_q;
	assign heading    = h_q;

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step && view.done))
		else $error("result without a completed frame");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(x_q) && $stable(h_q))
		else $error("pending result overwritten");

endmodule
